// ----- src/cossim_pkg.sv -----
// ----------------------------------------------------------------------------
// cossim_pkg
// Types and constants shared by the cosine similarity stream block.
// ----------------------------------------------------------------------------
package cossim_pkg;

	localparam int ELEM_W     = 16;
	localparam int PROD_W     = 2 * ELEM_W;
	localparam int SQ_W       = PROD_W - 1;     // a*a never exceeds 2^30
	localparam int DOT_W      = 48;
	localparam int NORM_W     = 47;
	localparam int ROOT_W     = (NORM_W + 1) / 2;
	localparam int DEN_W      = 2 * ROOT_W;
	localparam int FRAC_W     = 15;
	localparam int NUM_W      = DOT_W + FRAC_W;
	localparam int QUO_W      = 17;
	localparam int DSH_W      = DEN_W + QUO_W;
	localparam int CNT_W      = 5;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	localparam logic [QUO_W-1:0] POS_MAX = QUO_W'(32767);
	localparam logic [QUO_W-1:0] NEG_MAX = QUO_W'(32768);

	typedef struct packed {
		logic signed [ELEM_W-1:0] elem_a;
		logic signed [ELEM_W-1:0] elem_b;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] similarity;
		logic                     zero_vector;
	} result_t;

	typedef struct packed {
		logic [DOT_W-1:0]  dot;
		logic [NORM_W-1:0] norm_a;
		logic [NORM_W-1:0] norm_b;
	} sums_t;

	typedef struct packed {
		logic               empty;
		logic               almost_full;
		logic [FIFO_CW-1:0] count;
	} fifo_status_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SQRT,
		B_MUL,
		B_PREP,
		B_DIV,
		B_FIN,
		B_DONE
	} back_state_t;

endpackage

// ----- src/cossim_front.sv -----
// ----------------------------------------------------------------------------
// cossim_front
// Multiply stage and accumulators; pushes the finished sums on the last pair.
// ----------------------------------------------------------------------------
module cossim_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  cossim_pkg::item_t        item,
	input  cossim_pkg::fifo_status_t fifo_st,
	output logic                     push,
	output cossim_pkg::sums_t        push_data
);
	import cossim_pkg::*;

	logic                     accept;
	logic signed [PROD_W-1:0] p_ab, p_aa, p_bb;
	logic                     valid_s1;
	logic                     last_s1;
	logic signed [PROD_W-1:0] prod_ab_s1;
	logic [SQ_W-1:0]          prod_aa_s1, prod_bb_s1;
	logic [DOT_W-1:0]         dot_q, dot_next;
	logic [NORM_W-1:0]        na_q, na_next, nb_q, nb_next;

	// one slot is kept free for the transaction still in the multiply stage
	assign item_stall = fifo_st.almost_full;
	assign accept     = item_valid && !item_stall;

	assign p_ab = $signed(item.elem_a) * $signed(item.elem_b);
	assign p_aa = $signed(item.elem_a) * $signed(item.elem_a);
	assign p_bb = $signed(item.elem_b) * $signed(item.elem_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1    <= item.last;
			prod_ab_s1 <= p_ab;
			prod_aa_s1 <= p_aa[SQ_W-1:0];
			prod_bb_s1 <= p_bb[SQ_W-1:0];
		end
	end

	assign dot_next = dot_q + {{(DOT_W-PROD_W){prod_ab_s1[PROD_W-1]}}, prod_ab_s1};
	assign na_next  = na_q + {{(NORM_W-SQ_W){1'b0}}, prod_aa_s1};
	assign nb_next  = nb_q + {{(NORM_W-SQ_W){1'b0}}, prod_bb_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			na_q  <= '0;
			nb_q  <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				dot_q <= '0;
				na_q  <= '0;
				nb_q  <= '0;
			end else begin
				dot_q <= dot_next;
				na_q  <= na_next;
				nb_q  <= nb_next;
			end
		end
	end

	assign push             = valid_s1 && last_s1;
	assign push_data.dot    = dot_next;
	assign push_data.norm_a = na_next;
	assign push_data.norm_b = nb_next;

endmodule

// ----- src/cossim_fifo.sv -----
// ----------------------------------------------------------------------------
// cossim_fifo
// Short queue of finished sums between the accumulators and the back end.
// ----------------------------------------------------------------------------
module cossim_fifo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  cossim_pkg::sums_t        push_data,
	input  logic                     pop,
	output cossim_pkg::sums_t        pop_data,
	output cossim_pkg::fifo_status_t status
);
	import cossim_pkg::*;

	sums_t              entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_data           = entry_q[rd_ptr_q];
	assign status.count       = count_q;
	assign status.empty       = (count_q == '0);
	assign status.almost_full = (count_q >= FIFO_CW'(FIFO_DEPTH - 1));

endmodule

// ----- src/cossim_sqrt.sv -----
// ----------------------------------------------------------------------------
// cossim_sqrt
// Floor square root, digit by digit, one result bit per cycle.
// ----------------------------------------------------------------------------
module cossim_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cossim_pkg::NORM_W-1:0] x,
	output logic                          busy,
	output logic [cossim_pkg::ROOT_W-1:0] root
);
	import cossim_pkg::*;

	logic              busy_q;
	logic [NORM_W-1:0] rem_q;
	logic [NORM_W:0]   res_q;
	logic [NORM_W-1:0] bit_q;
	logic [NORM_W:0]   trial;
	logic              fits;

	assign trial = res_q + {1'b0, bit_q};
	assign fits  = ({1'b0, rem_q} >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= x;
			res_q <= '0;
			bit_q <= {1'b1, {(NORM_W-1){1'b0}}};
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - trial[NORM_W-1:0];
				res_q <= (res_q >> 1) + {1'b0, bit_q};
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

// ----- src/cossim_back.sv -----
// ----------------------------------------------------------------------------
// cossim_back
// Takes one set of sums at a time: roots, denominator, restoring divide,
// saturation and the result register.
// ----------------------------------------------------------------------------
module cossim_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cossim_pkg::fifo_status_t fifo_st,
	input  cossim_pkg::sums_t        pop_data,
	output logic                     pop,
	output logic                     result_valid,
	input  logic                     result_stall,
	output cossim_pkg::result_t      result
);
	import cossim_pkg::*;

	back_state_t       state_q, state_next;
	logic              sq_start;
	logic              busy_a, busy_b;
	logic [ROOT_W-1:0] root_a, root_b;
	logic              zero_in;
	logic              neg_q;
	logic [DOT_W-1:0]  mag_q;
	logic              zero_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  rem_q;
	logic [DSH_W-1:0]  dsh_q;
	logic [QUO_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              sat_q;
	logic              ge;
	logic [QUO_W-1:0]  neg_quo;
	result_t           result_q;

	assign zero_in = (pop_data.norm_a == '0) || (pop_data.norm_b == '0);
	assign ge      = ({{(DSH_W-NUM_W){1'b0}}, rem_q} >= dsh_q);
	assign neg_quo = {1'b1, {(QUO_W-1){1'b0}}} - quo_q;

	cossim_sqrt u_sqrt_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      (pop_data.norm_a),
		.busy   (busy_a),
		.root   (root_a)
	);

	cossim_sqrt u_sqrt_b (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      (pop_data.norm_b),
		.busy   (busy_b),
		.root   (root_b)
	);

	always_comb begin
		state_next = state_q;
		case (state_q)
			B_IDLE: begin
				if (!fifo_st.empty) begin
					state_next = zero_in ? B_FIN : B_SQRT;
				end
			end
			B_SQRT: begin
				if (!busy_a && !busy_b) begin
					state_next = B_MUL;
				end
			end
			B_MUL:  state_next = B_PREP;
			B_PREP: state_next = B_DIV;
			B_DIV: begin
				if ((cnt_q == CNT_W'(QUO_W)) && ge) begin
					state_next = B_FIN;
				end else if (cnt_q == '0) begin
					state_next = B_FIN;
				end
			end
			B_FIN: state_next = B_DONE;
			B_DONE: begin
				if (!result_stall) begin
					state_next = B_IDLE;
				end
			end
			default: state_next = B_IDLE;
		endcase
	end

	always_comb begin
		pop          = 1'b0;
		sq_start     = 1'b0;
		result_valid = 1'b0;
		case (state_q)
			B_IDLE: begin
				pop      = !fifo_st.empty;
				sq_start = !fifo_st.empty && !zero_in;
			end
			B_DONE:  result_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				neg_q  <= pop_data.dot[DOT_W-1];
				mag_q  <= pop_data.dot[DOT_W-1] ? (~pop_data.dot + 1'b1) : pop_data.dot;
				zero_q <= zero_in;
				sat_q  <= 1'b0;
			end
			B_MUL: begin
				den_q <= root_a * root_b;
			end
			B_PREP: begin
				rem_q <= {mag_q, {FRAC_W{1'b0}}};
				dsh_q <= {den_q, {QUO_W{1'b0}}};
				cnt_q <= CNT_W'(QUO_W);
				quo_q <= '0;
			end
			B_DIV: begin
				// top step only checks for a quotient of 2^17 or more
				if (cnt_q == CNT_W'(QUO_W)) begin
					sat_q <= ge;
				end else begin
					if (ge) begin
						rem_q <= rem_q - dsh_q[NUM_W-1:0];
					end
					quo_q <= {quo_q[QUO_W-2:0], ge};
				end
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			B_FIN: begin
				result_q.zero_vector <= zero_q;
				if (zero_q) begin
					result_q.similarity <= '0;
				end else if (neg_q) begin
					if (sat_q || quo_q > NEG_MAX) begin
						result_q.similarity <= {1'b1, {(ELEM_W-1){1'b0}}};
					end else begin
						result_q.similarity <= neg_quo[ELEM_W-1:0];
					end
				end else begin
					if (sat_q || quo_q > POS_MAX) begin
						result_q.similarity <= {1'b0, {(ELEM_W-1){1'b1}}};
					end else begin
						result_q.similarity <= quo_q[ELEM_W-1:0];
					end
				end
			end
			default: ;
		endcase
	end

	assign result = result_q;

endmodule

// ----- src/cosine_similarity_stream.sv -----
// ----------------------------------------------------------------------------
// cosine_similarity_stream
// Streaming cosine similarity of two Q1.15 vectors, one element pair per
// transaction, one saturated Q1.15 result per vector pair.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                    | payload
//  item     | in  | item_valid / item_stall      | elem_a, elem_b, last
//  result   | out | result_valid / result_stall  | similarity, zero_vector
//
// Element pairs are taken one per cycle while item_stall is low; the multiply-accumulate is a
// two-stage pipe. Each last pair queues its sums (4 entries) for the back end.
// Back end per vector pair, in order: a pop, the root (24 steps and the
// handoff), a multiply, a setup, up to 18 divide steps, a saturation step
// and the output register; a zero norm goes from the pop to saturation.
// Reset clears sums, queue and state; item_stall rises when the queue has 3
// entries, result waits in its register while result_stall is high.
// ----------------------------------------------------------------------------
module cosine_similarity_stream (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  cossim_pkg::item_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output cossim_pkg::result_t result
);
	import cossim_pkg::*;

	fifo_status_t fifo_st;
	logic         push, pop;
	sums_t        push_data, pop_data;

	cossim_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.fifo_st    (fifo_st),
		.push       (push),
		.push_data  (push_data)
	);

	cossim_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (fifo_st)
	);

	cossim_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_st      (fifo_st),
		.pop_data     (pop_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_st.count <= FIFO_CW'(FIFO_DEPTH))
		else $error("sums queue overflow");

	a_stall_when_nearly_full: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_st.count >= FIFO_CW'(FIFO_DEPTH - 1)) |-> item_stall)
		else $error("items taken with no room for their sums");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.zero_vector) |-> (result.similarity == '0))
		else $error("zero vector with nonzero similarity");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for cosine_similarity_stream. Element pairs go in with
// random gaps, results are taken with random stalls. A bit-exact software
// predictor (sums, floor roots, saturated Q1.15 quotient) supplies the
// expected similarity and zero-vector flag for every vector pair.
// ----------------------------------------------------------------------------
module tb_top;
	import cossim_pkg::*;

	localparam int CLK_HALF     = 10;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 1230;
	localparam int DRAIN_CYCLES = 60;

	typedef enum int {
		SHAPE_FULL,
		SHAPE_SMALL,
		SHAPE_EXTREME,
		SHAPE_PARALLEL,
		SHAPE_ANTI,
		SHAPE_A_ZERO,
		SHAPE_B_ZERO,
		SHAPE_SCALED
	} shape_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// predictor state
	logic [DOT_W-1:0]  dot_acc    = '0;
	logic [NORM_W-1:0] norm_a_acc = '0;
	logic [NORM_W-1:0] norm_b_acc = '0;
	result_t           pending_sims[$];

	bit tx_gaps_en  = 1'b1;
	bit rx_stall_en = 1'b1;
	int err_cnt     = 0;
	int pairs_sent  = 0;
	int sims_seen   = 0;
	int sat_cnt     = 0;
	int zero_cnt    = 0;
	int cycle_cnt   = 0;

	cosine_similarity_stream u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles, %0d results outstanding", $time,
				cycle_cnt, pending_sims.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [ROOT_W-1:0] root_floor(input logic [NORM_W-1:0] x);
		logic [ROOT_W-1:0] r;
		logic [ROOT_W-1:0] c;
		logic [DEN_W-1:0]  sq;
		r = '0;
		for (int i = ROOT_W - 1; i >= 0; i--) begin
			c  = r | (ROOT_W'(1) << i);
			sq = c * c;
			if (sq <= DEN_W'(x))
				r = c;
		end
		return r;
	endfunction

	// Fold one accepted pair into the sums; on last, queue the expected result.
	function automatic void fold_pair(input item_t it);
		longint      a;
		longint      b;
		logic        neg;
		logic [47:0] mag;
		logic [63:0] den;
		logic [63:0] q;
		result_t     r;
		a = $signed(it.elem_a);
		b = $signed(it.elem_b);
		dot_acc    = dot_acc + DOT_W'(a * b);
		norm_a_acc = norm_a_acc + NORM_W'(a * a);
		norm_b_acc = norm_b_acc + NORM_W'(b * b);
		if (!it.last)
			return;
		if (norm_a_acc == 0 || norm_b_acc == 0) begin
			r.similarity  = '0;
			r.zero_vector = 1'b1;
			zero_cnt++;
		end else begin
			neg = dot_acc[DOT_W-1];
			mag = neg ? DOT_W'(-dot_acc) : dot_acc;
			den = 64'(root_floor(norm_a_acc)) * 64'(root_floor(norm_b_acc));
			q   = 64'(mag) << FRAC_W;
			q   = q / den;
			if (neg) begin
				if (q > 64'd32768) begin
					q = 64'd32768;
					sat_cnt++;
				end
				r.similarity = 16'(64'd0 - q);
			end else begin
				if (q > 64'd32767) begin
					q = 64'd32767;
					sat_cnt++;
				end
				r.similarity = 16'(q);
			end
			r.zero_vector = 1'b0;
		end
		pending_sims.push_back(r);
		dot_acc    = '0;
		norm_a_acc = '0;
		norm_b_acc = '0;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Drive one transaction; returns at the edge where it is accepted.
	task automatic send_item(input item_t it);
		int gap;
		gap = tx_gaps_en ? pick_gap() : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		pairs_sent++;
		fold_pair(it);
	endtask

	task automatic send_pair(input int a, input int b, input bit last);
		send_item('{elem_a: 16'(a), elem_b: 16'(b), last: last});
	endtask

	function automatic logic signed [15:0] pick_value(input shape_t shape);
		int roll;
		case (shape)
			SHAPE_SMALL:   return 16'($urandom_range(0, 255) - 128);
			SHAPE_EXTREME: begin
				roll = $urandom_range(0, 4);
				case (roll)
					0:       return 16'sh8000;
					1:       return 16'sh7fff;
					2:       return -16'sd1;
					3:       return 16'sd0;
					default: return 16'sd1;
				endcase
			end
			default:       return 16'($urandom);
		endcase
	endfunction

	task automatic send_vector(input int len, input shape_t shape);
		logic signed [15:0] a;
		logic signed [15:0] b;
		int                 k;
		k = $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			a = pick_value(shape);
			case (shape)
				SHAPE_SMALL, SHAPE_EXTREME: b = pick_value(shape);
				SHAPE_PARALLEL:             b = a;
				SHAPE_ANTI:                 b = -a;
				SHAPE_A_ZERO: begin
					b = a;
					a = '0;
				end
				SHAPE_B_ZERO:               b = '0;
				SHAPE_SCALED:               b = a >>> k;
				default:                    b = pick_value(SHAPE_FULL);
			endcase
			send_item('{elem_a: a, elem_b: b, last: (i == len - 1)});
		end
	endtask

	// Result checker
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			sims_seen++;
			if (pending_sims.size() == 0) begin
				$display("%0t ERROR unexpected result: similarity %0d zero_vector %0b", $time,
					$signed(result.similarity), result.zero_vector);
				err_cnt++;
			end else begin
				want = pending_sims.pop_front();
				if (result.similarity !== want.similarity) begin
					$display("%0t ERROR similarity: expected %0d, actual %0d", $time,
						$signed(want.similarity), $signed(result.similarity));
					err_cnt++;
				end
				if (result.zero_vector !== want.zero_vector) begin
					$display("%0t ERROR zero_vector: expected %0b, actual %0b", $time,
						want.zero_vector, result.zero_vector);
					err_cnt++;
				end
			end
		end
	end

	// Receiver stall pattern: mostly free, short stalls, now and then a long one
	always @(posedge clk) begin : result_idle
		int roll;
		static int stall_left = 0;
		if (!rx_stall_en) begin
			stall_left = 0;
			result_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				result_stall <= 1'b0;
			end else if (roll < 95) begin
				stall_left = $urandom_range(0, 2);
				result_stall <= 1'b1;
			end else begin
				stall_left = $urandom_range(10, 40);
				result_stall <= 1'b1;
			end
		end
	end

	task automatic test_corner_values();
		send_pair(32767, 32767, 1'b1);       // parallel, a ratio of 1.0 saturates to the positive maximum
		send_pair(-32768, -32768, 1'b1);
		send_pair(-32768, 32767, 1'b1);      // opposite signs, lands exactly on the negative maximum
		send_pair(32767, -32768, 1'b1);
		send_pair(1, 1, 1'b1);
	endtask

	task automatic test_zero_norms();
		send_pair(0, 0, 1'b1);
		send_pair(0, 1234, 1'b1);
		send_pair(-1, 0, 1'b1);
		send_pair(0, 5, 1'b0);
		send_pair(0, -5, 1'b1);
	endtask

	task automatic test_multi_pair();
		send_pair(1, 0, 1'b0);               // orthogonal
		send_pair(0, 1, 1'b1);
		send_pair(100, -100, 1'b0);
		send_pair(200, -200, 1'b0);
		send_pair(-300, 300, 1'b1);
		send_pair(32767, -1, 1'b0);          // sums carry across non-last pairs
		send_pair(-32768, 1, 1'b0);
		send_pair(5, 5, 1'b1);
	endtask

	task automatic test_random_vectors();
		int     start;
		int     len;
		int     roll;
		shape_t shape;
		start = pairs_sent;
		while (pairs_sent - start < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 70)
				len = $urandom_range(1, 8);
			else if (roll < 95)
				len = $urandom_range(9, 40);
			else
				len = $urandom_range(41, 300);
			shape       = shape_t'($urandom_range(SHAPE_FULL, SHAPE_SCALED));
			// some vectors run at full rate on both sides
			tx_gaps_en  = ($urandom_range(0, 99) >= 15);
			rx_stall_en = tx_gaps_en;
			send_vector(len, shape);
		end
		tx_gaps_en  = 1'b1;
		rx_stall_en = 1'b1;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_values();
		test_zero_norms();
		test_multi_pair();
		test_random_vectors();

		item_valid <= 1'b0;
		while (pending_sims.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d element pairs, checked %0d similarity results", pairs_sent,
			sims_seen);
		$display("  %0d of them saturated, %0d flagged zero-vector, %0d errors", sat_cnt,
			zero_cnt, err_cnt);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/cossim_pkg.sv
src/cossim_front.sv
src/cossim_fifo.sv
src/cossim_sqrt.sv
src/cossim_back.sv
src/cosine_similarity_stream.sv
bench/tb_top.sv
